// ----- rtl/core/stereo_rms_vu_meter_defines.svh -----
// ----------------------------------------------------------------------------
// Stereo RMS VU meter - assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_RMS_VU_METER_DEFINES_SVH
`define STEREO_RMS_VU_METER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SVM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("stereo_rms_vu_meter: check failed");

// antecedent implies consequent from the next cycle on
`define SVM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("stereo_rms_vu_meter: check failed");

`endif

// ----- rtl/core/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg
// Widths, constants and types shared by the stereo RMS meter modules.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int WINDOW = 1024;
  localparam int POS_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SMP_W  = 16;
  localparam int GAIN_W = 16;
  localparam int LVL_W  = 8;
  localparam int SQ_W   = 31;              // square of a Q1.15 sample
  localparam int SUM_W  = SQ_W + POS_W;    // window sum of squares
  localparam int MANT_W = 31;              // Q30 mantissa
  localparam int FRAC_W = 16;
  localparam int P_W    = $clog2(SUM_W);
  localparam int LG_W   = P_W + FRAC_W;
  localparam int L2_W   = LG_W + 2;
  localparam int K_W    = 21;
  localparam int PROD_W = L2_W + K_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int MEM_W  = 2 * SMP_W;

  localparam logic [GAIN_W-1:0]       GAIN_RESET = GAIN_W'(4096);
  // 4.25 * 10*log10(2) in Q16
  localparam logic signed [K_W-1:0]   LEVEL_K    = K_W'(838453);
  // 2^54 scale of sum (Q30) times gain squared (Q24), in Q16
  localparam logic signed [L2_W-1:0]  L2_BIAS    = L2_W'(54 * 65536);
  // 255 in Q32 plus half an LSB for rounding
  localparam logic signed [ACC_W-1:0] ACC_BIAS   = ACC_W'(64'h0000_00FF_8000_0000);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_LOG1,
    ST_WAIT1,
    ST_LOG2,
    ST_WAIT2,
    ST_LEVEL,
    ST_LVWAIT,
    ST_DONE
  } svm_state_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQR
  } svm_lg_state_t;

  typedef struct packed {
    logic            busy;
    logic [LG_W-1:0] lg;
  } svm_lg_res_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] level;
  } svm_lvl_res_t;

endpackage

// ----- rtl/core/svm_hist_mem.sv -----
// ----------------------------------------------------------------------------
// svm_hist_mem
// Sample history RAM, both channels per entry, registered read port.
// ----------------------------------------------------------------------------
module svm_hist_mem
  import svm_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [POS_W-1:0] rd_addr,
  output logic [MEM_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [POS_W-1:0] wr_addr,
  input  logic [MEM_W-1:0] wr_data
);

  logic [MEM_W-1:0] mem [WINDOW];
  logic [MEM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/svm_log2.sv -----
// ----------------------------------------------------------------------------
// svm_log2
// Iterative log2 in Q16: normalize, then 16 squarings of a Q30 mantissa.
// ----------------------------------------------------------------------------
module svm_log2
  import svm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] value,
  output svm_lg_res_t      res
);

  svm_lg_state_t      state_r, state_nxt;
  logic [SUM_W-1:0]   x_r, x_nxt;
  logic [P_W-1:0]     p_r, p_nxt;
  logic [MANT_W-1:0]  m_r, m_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]    sq_top;
  logic               shift8, shift1;

  assign shift8 = (p_r >= P_W'(8)) && (x_r[SUM_W-1 -: 8] == 8'd0);
  assign shift1 = (p_r != '0) && !x_r[SUM_W-1];
  assign sq     = m_r * m_r;
  assign sq_top = sq[2*MANT_W-1 -: MANT_W+1];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      LG_IDLE: begin
        if (start) state_nxt = LG_NORM;
      end
      LG_NORM: begin
        if (!shift8 && !shift1) state_nxt = LG_SQR;
      end
      LG_SQR: begin
        if (cnt_r == 4'd0) state_nxt = LG_IDLE;
      end
      default: state_nxt = LG_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    x_nxt    = x_r;
    p_nxt    = p_r;
    m_nxt    = m_r;
    frac_nxt = frac_r;
    cnt_nxt  = cnt_r;
    unique case (state_r)
      LG_IDLE: begin
        if (start) begin
          x_nxt = value;
          p_nxt = P_W'(SUM_W - 1);
        end
      end
      LG_NORM: begin
        if (shift8) begin
          x_nxt = {x_r[SUM_W-9:0], 8'd0};
          p_nxt = p_r - P_W'(8);
        end else if (shift1) begin
          x_nxt = {x_r[SUM_W-2:0], 1'b0};
          p_nxt = p_r - P_W'(1);
        end else begin
          // top bit now at SUM_W-1: the Q30 mantissa is the top MANT_W bits
          m_nxt    = x_r[SUM_W-1 -: MANT_W];
          frac_nxt = '0;
          cnt_nxt  = 4'd15;
        end
      end
      LG_SQR: begin
        if (sq_top[MANT_W]) begin
          m_nxt           = sq_top[MANT_W:1];
          frac_nxt[cnt_r] = 1'b1;
        end else begin
          m_nxt = sq_top[MANT_W-1:0];
        end
        cnt_nxt = cnt_r - 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    p_r    <= p_nxt;
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign res.busy = (state_r != LG_IDLE);
  assign res.lg   = {p_r, frac_r};

endmodule

// ----- rtl/core/svm_level.sv -----
// ----------------------------------------------------------------------------
// svm_level
// Three-stage dB-to-level mapping: combine logs, scale, round and clamp.
// ----------------------------------------------------------------------------
module svm_level
  import svm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            zero,
  input  logic [LG_W-1:0] lg_sum,
  input  logic [LG_W-1:0] lg_gain,
  input  logic [LG_W-1:0] lg_cnt,
  output svm_lvl_res_t    res
);

  logic                     v1_r, v2_r, done_r;
  logic                     z1_r, z2_r;
  logic signed [L2_W-1:0]   l2_r, l2_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc;
  logic [LVL_W-1:0]         level_r, level_nxt;

  // log2 of power = lg(S) + 2 lg(G) - lg(n) - 54, Q16
  assign l2_nxt = $signed({2'b00, lg_sum}) + $signed({1'b0, lg_gain, 1'b0})
                - $signed({2'b00, lg_cnt}) - L2_BIAS;

  assign acc = ACC_BIAS + ACC_W'(prod_r);

  always_comb begin
    if (z2_r || acc[ACC_W-1]) begin
      level_nxt = '0;
    end else if (acc[ACC_W-2:32+LVL_W] != '0) begin
      level_nxt = '1;
    end else begin
      level_nxt = acc[32 +: LVL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    l2_r    <= l2_nxt;
    z1_r    <= zero;
    prod_r  <= LEVEL_K * l2_r;
    z2_r    <= z1_r;
    level_r <= level_nxt;
  end

  assign res.done  = done_r;
  assign res.level = level_r;

endmodule

// ----- rtl/core/stereo_rms_vu_meter.sv -----
// ----------------------------------------------------------------------------
// stereo_rms_vu_meter
// Sliding-window stereo RMS meter with 8-bit dB-scaled levels.
// ----------------------------------------------------------------------------
// One stereo frame is taken at a time and yields one transaction holding both
// levels. A frame occupies the block until its result has been loaded into the
// output register. The accept, the history RAM read and the sum update are
// the IDLE, READ and SUM states. Two shared log2 units then run two passes
// each: the sums of squares, then gain and sample count. A pass is a start, a
// normalize, the squarings and a handoff, and lasts as long as the slower
// unit. The dB mapping and one output load follow. The finished result sits
// in an output register, so the next frame is taken while it waits. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
module stereo_rms_vu_meter
  import svm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] in_left_sample,
  input  logic signed [SMP_W-1:0] in_right_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LVL_W-1:0]        out_left_level,
  output logic [LVL_W-1:0]        out_right_level,
  input  logic                    cfg_wr_en,
  input  logic [GAIN_W-1:0]       cfg_level_gain
);

  svm_state_t state_r, state_nxt;

  logic                    in_accept;
  logic                    rd_en, wr_en, lg_start, first_pass, lvl_start;
  logic                    capture1, capture2, out_load;
  logic                    full;
  logic [MEM_W-1:0]        rd_data;

  logic [GAIN_W-1:0]       gain_r;
  logic [POS_W-1:0]        pos_r;
  logic [CNT_W-1:0]        seen_r;
  logic [SUM_W-1:0]        sum_l_r, sum_rt_r;
  logic signed [SMP_W-1:0] smp_l_r, smp_rt_r;
  logic signed [SMP_W-1:0] old_l, old_rt;
  logic signed [2*SMP_W-1:0] prod_nl, prod_nr, prod_ol, prod_or;
  logic [SQ_W-1:0]         sq_nl_r, sq_nr_r, sq_ol_r, sq_or_r;
  logic [LG_W-1:0]         lg_sl_r, lg_sr_r, lg_g_r, lg_n_r;
  logic [LVL_W-1:0]        lvl_l_r, lvl_rt_r;
  logic                    out_valid_r;
  logic [LVL_W-1:0]        out_l_r, out_rt_r;

  logic [SUM_W-1:0]        lga_val, lgb_val;
  svm_lg_res_t             lga_res, lgb_res;
  svm_lvl_res_t            lvl_l_res, lvl_rt_res;

  assign in_accept = in_valid && !in_stall;
  assign full      = (seen_r == CNT_W'(WINDOW));

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_LOG1;
      ST_LOG1:   state_nxt = ST_WAIT1;
      ST_WAIT1:  if (!lga_res.busy && !lgb_res.busy) state_nxt = ST_LOG2;
      ST_LOG2:   state_nxt = ST_WAIT2;
      ST_WAIT2:  if (!lga_res.busy && !lgb_res.busy) state_nxt = ST_LEVEL;
      ST_LEVEL:  state_nxt = ST_LVWAIT;
      ST_LVWAIT: if (lvl_l_res.done) state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    lg_start   = 1'b0;
    first_pass = 1'b0;
    capture1   = 1'b0;
    capture2   = 1'b0;
    lvl_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
      end
      ST_READ:   wr_en = 1'b1;
      ST_LOG1: begin
        lg_start   = 1'b1;
        first_pass = 1'b1;
      end
      ST_WAIT1:  capture1 = !lga_res.busy && !lgb_res.busy;
      ST_LOG2:   lg_start = 1'b1;
      ST_WAIT2:  capture2 = !lga_res.busy && !lgb_res.busy;
      ST_LEVEL:  lvl_start = 1'b1;
      ST_DONE:   out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // history RAM and running sums
  // --------------------------------------------------------------------------
  svm_hist_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (pos_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pos_r),
    .wr_data ({smp_l_r, smp_rt_r})
  );

  assign old_l   = rd_data[MEM_W-1 -: SMP_W];
  assign old_rt  = rd_data[SMP_W-1:0];
  assign prod_nl = smp_l_r * smp_l_r;
  assign prod_nr = smp_rt_r * smp_rt_r;
  assign prod_ol = old_l * old_l;
  assign prod_or = old_rt * old_rt;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      smp_l_r  <= in_left_sample;
      smp_rt_r <= in_right_sample;
    end
    if (state_r == ST_READ) begin
      sq_nl_r <= prod_nl[SQ_W-1:0];
      sq_nr_r <= prod_nr[SQ_W-1:0];
      // history slot only leaves the window once the window is full
      sq_ol_r <= full ? prod_ol[SQ_W-1:0] : '0;
      sq_or_r <= full ? prod_or[SQ_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      pos_r    <= '0;
      seen_r   <= '0;
      sum_l_r  <= '0;
      sum_rt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_level_gain;
      end
      if (state_r == ST_SUM) begin
        sum_l_r  <= sum_l_r - SUM_W'(sq_ol_r) + SUM_W'(sq_nl_r);
        sum_rt_r <= sum_rt_r - SUM_W'(sq_or_r) + SUM_W'(sq_nr_r);
        pos_r    <= (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + POS_W'(1);
        if (!full) begin
          seen_r <= seen_r + CNT_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // log2 units: pass one on the sums, pass two on gain (A) and count (B)
  // --------------------------------------------------------------------------
  assign lga_val = first_pass ? sum_l_r  : SUM_W'(gain_r);
  assign lgb_val = first_pass ? sum_rt_r : SUM_W'(seen_r);

  svm_log2 u_lga (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lg_start),
    .value (lga_val),
    .res   (lga_res)
  );

  svm_log2 u_lgb (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lg_start),
    .value (lgb_val),
    .res   (lgb_res)
  );

  always_ff @(posedge clk) begin
    if (capture1) begin
      lg_sl_r <= lga_res.lg;
      lg_sr_r <= lgb_res.lg;
    end
    if (capture2) begin
      lg_g_r <= lga_res.lg;
      lg_n_r <= lgb_res.lg;
    end
  end

  // --------------------------------------------------------------------------
  // level mapping
  // --------------------------------------------------------------------------
  svm_level u_lvl_l (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lvl_start),
    .zero    ((sum_l_r == '0) || (gain_r == '0)),
    .lg_sum  (lg_sl_r),
    .lg_gain (lg_g_r),
    .lg_cnt  (lg_n_r),
    .res     (lvl_l_res)
  );

  svm_level u_lvl_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lvl_start),
    .zero    ((sum_rt_r == '0) || (gain_r == '0)),
    .lg_sum  (lg_sr_r),
    .lg_gain (lg_g_r),
    .lg_cnt  (lg_n_r),
    .res     (lvl_rt_res)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_LVWAIT && lvl_l_res.done) begin
      lvl_l_r  <= lvl_l_res.level;
      lvl_rt_r <= lvl_rt_res.level;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l_r  <= lvl_l_r;
      out_rt_r <= lvl_rt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_level  = out_l_r;
  assign out_right_level = out_rt_r;

endmodule

// ----- rtl/core/svm_checker.sv -----
// ----------------------------------------------------------------------------
// svm_checker
// Port-level checks for the stereo RMS meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_rms_vu_meter_defines.svh"

module svm_checker
  import svm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [LVL_W-1:0] out_left_level,
  input logic [LVL_W-1:0] out_right_level
);

  // a stalled result transaction holds
  `SVM_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(out_left_level) && $stable(out_right_level))

  // a frame still stalls the input when its sum update is made
  `SVM_ASSERT_IMP(a_busy_after_accept, in_valid && !in_stall, ##2 in_stall)

  // a new result only comes out of a busy block
  `SVM_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind stereo_rms_vu_meter svm_checker u_svm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_left_level  (out_left_level),
  .out_right_level (out_right_level)
);
